>>> sv/box3d_pkg.sv
// shared widths, types and helpers for the 3d box overlap ratio pipeline
package box3d_pkg;
  localparam int FIELD_W = 16;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int OVL_W = 18;
  localparam int VOL_W = 51;
  localparam int QUO_W = RATIO_FRAC_BITS + 1;
  localparam int REM_W = VOL_W + 2;
  localparam int DIV_STAGES = 8;
  // the first quotient bit is settled before the division stages
  localparam int BITS_PER_STAGE = (QUO_W - 1 + DIV_STAGES - 1) / DIV_STAGES;
  localparam int OUT_W = 16;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [VOL_W:0]   den;
    logic [QUO_W-1:0] quo;
    logic             zero;
  } div_t;

  // one restoring division step
  function automatic div_t div_step(input div_t d);
    div_t o;
    logic [REM_W-1:0] r2;
    o = d;
    r2 = {d.rem[REM_W-2:0], 1'b0};
    o.quo = {d.quo[QUO_W-2:0], 1'b0};
    if (r2 >= {1'b0, d.den}) begin
      r2 = r2 - {1'b0, d.den};
      o.quo[0] = 1'b1;
    end
    o.rem = r2;
    return o;
  endfunction
endpackage

>>> sv/box3d_axis.sv
// overlap length along one axis in doubled units
module box3d_axis import box3d_pkg::*; (
  input  logic signed [FIELD_W-1:0] ca,
  input  logic        [FIELD_W-1:0] sa,
  input  logic signed [FIELD_W-1:0] cb,
  input  logic        [FIELD_W-1:0] sb,
  output logic        [OVL_W-1:0]   ovl
);
  logic signed [FIELD_W+2:0] lo_a, hi_a, lo_b, hi_b, lo, hi, d;
  always_comb begin
    lo_a = {{2{ca[FIELD_W-1]}}, ca, 1'b0} - $signed({3'b000, sa});
    hi_a = {{2{ca[FIELD_W-1]}}, ca, 1'b0} + $signed({3'b000, sa});
    lo_b = {{2{cb[FIELD_W-1]}}, cb, 1'b0} - $signed({3'b000, sb});
    hi_b = {{2{cb[FIELD_W-1]}}, cb, 1'b0} + $signed({3'b000, sb});
    lo = (lo_a > lo_b) ? lo_a : lo_b;
    hi = (hi_a < hi_b) ? hi_a : hi_b;
    d = hi - lo;
    ovl = (hi > lo) ? d[OVL_W-1:0] : '0;
  end
endmodule

>>> sv/box3d_iou.sv
// top level: pipelined overlap ratio of two axis-aligned 3d boxes
// one box pair enters on the s_axis channel, one ratio leaves on m_axis.
// s_axis_tdata packs twelve 16-bit fields: a center x,y,z, a size x,y,z,
// then b center x,y,z, b size x,y,z, lowest bits first.
// m_axis_tdata holds the ratio (unsigned q0.16), m_axis_tuser the zero-union
// flag; the ratio is 0 when the flag is set.
// the pipeline stages are: axis overlap, two product stages, union with the
// first quotient bit, eight restoring division stages of two quotient bits
// each, and the output.
// throughput is one pair per cycle while m_axis takes results; every stage has its own valid bit.
// the pipeline advances whenever the output register is empty or taken, so
// a stalled receiver holds all stages and s_axis_tready drops with it.
// synchronous reset clears the valid bits only; nothing else is kept.
module box3d_iou import box3d_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [191:0]   s_axis_tdata,  // acx,acy,acz,asx,asy,asz,bcx,bcy,bcz,bsx,bsy,bsz
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata, // iou_ratio
  output logic           m_axis_tuser   // union_zero
);
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic [FIELD_W-1:0] f [12];
  always_comb for (int i = 0; i < 12; i++) f[i] = s_axis_tdata[i*FIELD_W +: FIELD_W];

  logic [OVL_W-1:0] ox, oy, oz;
  box3d_axis u_x (.ca(f[0]), .sa(f[3]), .cb(f[6]), .sb(f[9]),  .ovl(ox));
  box3d_axis u_y (.ca(f[1]), .sa(f[4]), .cb(f[7]), .sb(f[10]), .ovl(oy));
  box3d_axis u_z (.ca(f[2]), .sa(f[5]), .cb(f[8]), .sb(f[11]), .ovl(oz));

  // stage 1
  logic v1;
  logic [OVL_W-1:0] s1_ox, s1_oy, s1_oz;
  logic [FIELD_W:0] s1_a [3];
  logic [FIELD_W:0] s1_b [3];
  // stage 2: pairwise products
  logic v2;
  logic [2*OVL_W-1:0] s2_ixy;
  logic [OVL_W-1:0] s2_oz;
  logic [2*FIELD_W+1:0] s2_axy, s2_bxy;
  logic [FIELD_W:0] s2_az, s2_bz;
  // stage 3: full volumes
  logic v3;
  logic [VOL_W+1:0] s3_i, s3_va, s3_vb;
  // division stages
  logic vd [DIV_STAGES+1];
  div_t dd [DIV_STAGES+1];

  logic [VOL_W+1:0] uni;
  assign uni = s3_va + s3_vb - s3_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) vd[k] <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid; v2 <= v1; v3 <= v2; vd[0] <= v3;
      for (int k = 1; k <= DIV_STAGES; k++) vd[k] <= vd[k-1];
      m_axis_tvalid <= vd[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ox <= ox; s1_oy <= oy; s1_oz <= oz;
      for (int i = 0; i < 3; i++) begin
        s1_a[i] <= {f[3+i], 1'b0};
        s1_b[i] <= {f[9+i], 1'b0};
      end
      s2_ixy <= s1_ox * s1_oy;
      s2_oz <= s1_oz;
      s2_axy <= s1_a[0] * s1_a[1];
      s2_bxy <= s1_b[0] * s1_b[1];
      s2_az <= s1_a[2];
      s2_bz <= s1_b[2];
      s3_i  <= (VOL_W+2)'(s2_ixy * s2_oz);
      s3_va <= (VOL_W+2)'(s2_axy * s2_az);
      s3_vb <= (VOL_W+2)'(s2_bxy * s2_bz);
      // first quotient bit: intersection never exceeds the union
      dd[0].den  <= uni[VOL_W:0];
      dd[0].zero <= (uni == '0);
      if (s3_i >= uni) begin
        dd[0].rem <= REM_W'(s3_i - uni);
        dd[0].quo <= QUO_W'(1);
      end else begin
        dd[0].rem <= REM_W'(s3_i);
        dd[0].quo <= '0;
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
        div_t t;
        t = dd[k];
        for (int j = 0; j < BITS_PER_STAGE; j++)
          if (k*BITS_PER_STAGE + j < QUO_W - 1) t = div_step(t);
        dd[k+1] <= t;
      end
      if (dd[DIV_STAGES].zero) begin
        m_axis_tdata <= '0;
      end else if (dd[DIV_STAGES].quo > QUO_W'({OUT_W{1'b1}})) begin
        m_axis_tdata <= {OUT_W{1'b1}};
      end else begin
        m_axis_tdata <= dd[DIV_STAGES].quo[OUT_W-1:0];
      end
      m_axis_tuser <= dd[DIV_STAGES].zero;
    end
  end
endmodule

>>> dv/tb_box3d_iou.sv
// self-checking testbench for the 3d box overlap ratio pipeline
module tb_box3d_iou;
  import box3d_pkg::*;

  localparam int N_RANDOM = 830;
  localparam int WATCHDOG = 2000;

  typedef struct packed {
    logic [15:0] bsz, bsy, bsx, bcz, bcy, bcx;
    logic [15:0] asz, asy, asx, acz, acy, acx;
  } box_pair_t;

  typedef struct packed {
    logic [15:0] ratio;
    logic        uzero;
  } iou_t;

  typedef struct {
    box_pair_t pair;
    logic      has_exp;
    iou_t      exp;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  iou_t expected_iou[$];
  int   errors = 0;
  int   n_sent = 0;
  int   n_recv = 0;
  int   n_zero_union = 0;
  int   n_saturated = 0;
  int   idle_cycles = 0;
  bit   sending_done = 0;
  bit   hold_off = 0;

  box3d_iou DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  // overlap along one axis in doubled units
  function automatic longint unsigned overlap2(logic [15:0] ca, logic [15:0] sa,
                                               logic [15:0] cb, logic [15:0] sb);
    longint a2, b2, la, lb, lo, hi;
    a2 = 2 * longint'($signed(ca));
    b2 = 2 * longint'($signed(cb));
    la = longint'(sa);
    lb = longint'(sb);
    lo = (a2 - la > b2 - lb) ? a2 - la : b2 - lb;
    hi = (a2 + la < b2 + lb) ? a2 + la : b2 + lb;
    return (hi > lo) ? longint'(hi - lo) : 0;
  endfunction

  function automatic iou_t predict_iou(box_pair_t p);
    longint unsigned inter, va, vb, uni, q, r;
    iou_t o;
    inter = overlap2(p.acx, p.asx, p.bcx, p.bsx) * overlap2(p.acy, p.asy, p.bcy, p.bsy)
            * overlap2(p.acz, p.asz, p.bcz, p.bsz);
    va = (2 * longint'(p.asx)) * (2 * longint'(p.asy)) * (2 * longint'(p.asz));
    vb = (2 * longint'(p.bsx)) * (2 * longint'(p.bsy)) * (2 * longint'(p.bsz));
    uni = va + vb - inter;
    o.uzero = (uni == 0);
    o.ratio = '0;
    if (uni != 0) begin
      q = 0;
      r = inter;
      if (r >= uni) begin
        q = 1;
        r -= uni;
      end
      for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
        r <<= 1;
        q <<= 1;
        if (r >= uni) begin
          r -= uni;
          q |= 1;
        end
      end
      if (q > 65535) q = 65535;
      o.ratio = q[15:0];
    end
    return o;
  endfunction

  function automatic box_pair_t mk(int acx, int acy, int acz, int asx, int asy, int asz,
                                   int bcx, int bcy, int bcz, int bsx, int bsy, int bsz);
    box_pair_t p;
    p.acx = 16'(acx); p.acy = 16'(acy); p.acz = 16'(acz);
    p.asx = 16'(asx); p.asy = 16'(asy); p.asz = 16'(asz);
    p.bcx = 16'(bcx); p.bcy = 16'(bcy); p.bcz = 16'(bcz);
    p.bsx = 16'(bsx); p.bsy = 16'(bsy); p.bsz = 16'(bsz);
    return p;
  endfunction

  function automatic logic [15:0] rnd_size();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 8));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly nearby pairs: b's center is usually a's offset by -256..255 per axis
  function automatic box_pair_t rnd_pair();
    box_pair_t p;
    p = box_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    p.asx = rnd_size(); p.asy = rnd_size(); p.asz = rnd_size();
    p.bsx = rnd_size(); p.bsy = rnd_size(); p.bsz = rnd_size();
    if ($urandom_range(0, 3) != 0) begin
      p.bcx = p.acx + 16'($urandom_range(0, 511)) - 16'd256;
      p.bcy = p.acy + 16'($urandom_range(0, 511)) - 16'd256;
      p.bcz = p.acz + 16'($urandom_range(0, 511)) - 16'd256;
      if ($urandom_range(0, 7) == 0) p = mk(p.acx, p.acy, p.acz, p.asx, p.asy, p.asz,
                                            p.acx, p.acy, p.acz, p.asx, p.asy, p.asz);
    end
    return p;
  endfunction

  function automatic void queue_expected(iou_t v);
    expected_iou = {expected_iou, v};
  endfunction

  task automatic send_pair(box_pair_t p);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= p;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    queue_expected(predict_iou(p));
    n_sent++;
  endtask

  dir_row_t dir_rows[$];

  function automatic void add_row(box_pair_t p, logic has, iou_t e);
    dir_row_t row;
    row.pair = p;
    row.has_exp = has;
    row.exp = e;
    dir_rows = {dir_rows, row};
  endfunction

  // stimulus
  initial begin
    box_pair_t p;
    add_row(mk(0,0,0,0,0,0, 0,0,0,0,0,0), 1, '{16'd0, 1'b1});
    add_row(mk(0,0,0,256,256,256, 0,0,0,256,256,256), 1, '{16'hFFFF, 1'b0});
    add_row(mk(0,0,0,65535,65535,65535, 0,0,0,65535,65535,65535), 1, '{16'hFFFF, 1'b0});
    add_row(mk(0,0,0,0,256,256, 0,0,0,256,256,256), 1, '{16'd0, 1'b0});
    add_row(mk(0,0,0,256,256,256, 256,0,0,256,256,256), 1, '{16'd0, 1'b0});
    add_row(mk(-32768,-32768,-32768,256,256,256, 32767,32767,32767,256,256,256),
            1, '{16'd0, 1'b0});
    add_row(mk(-32768,32767,-32768,65535,65535,65535,
               32767,-32768,32767,65535,65535,65535), 0, '{16'd0, 1'b0});
    add_row(mk(0,0,0,512,512,512, 0,0,0,256,256,256), 1, '{16'd8192, 1'b0});
    add_row(mk(0,0,0,256,256,256, 128,0,0,256,256,256), 0, '{16'd0, 1'b0});
    add_row(mk(0,0,0,1,1,1, 0,0,0,0,0,0), 1, '{16'd0, 1'b0});
    add_row(mk(100,-100,5,3,7,11, 101,-99,4,5,9,13), 0, '{16'd0, 1'b0});
    add_row(mk(0,0,0,1,1,1, 0,0,0,1,1,1), 1, '{16'hFFFF, 1'b0});
    repeat (2) @(posedge clk);
    rst <= 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp && predict_iou(dir_rows[i].pair) != dir_rows[i].exp) begin
        $display("%0t directed row %0d: table %h predictor %h", $time, i,
                 dir_rows[i].exp, predict_iou(dir_rows[i].pair));
        errors++;
      end
      send_pair(dir_rows[i].pair);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      p = rnd_pair();
      send_pair(p);
    end
    s_axis_tvalid <= 0;
    sending_done = 1;
  end

  // receiver: a random wait before each transfer plus one long hold-off
  initial begin
    int wait_n;
    @(negedge rst);
    forever begin
      wait_n = $urandom_range(0, 3);
      if (!hold_off && n_sent > 300) begin
        hold_off = 1;
        wait_n = 40;
      end
      if (wait_n > 0) begin
        m_axis_tready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // result checking
  always @(posedge clk) begin
    iou_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata, m_axis_tuser};
      n_recv++;
      if (got.uzero) n_zero_union++;
      if (got.ratio == 16'hFFFF) n_saturated++;
      if (expected_iou.size() == 0) begin
        $display("%0t unexpected transfer: got %h", $time, got);
        errors++;
      end else begin
        want = expected_iou.pop_front();
        if (got.ratio !== want.ratio) begin
          $display("%0t iou_ratio: expected %h actual %h", $time, want.ratio, got.ratio);
          errors++;
        end
        if (got.uzero !== want.uzero) begin
          $display("%0t union_zero: expected %b actual %b", $time, want.uzero, got.uzero);
          errors++;
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(negedge rst);
    while (!(sending_done && expected_iou.size() == 0) && idle_cycles < WATCHDOG)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout with %0d results outstanding", expected_iou.size());
      $display("box3d_iou: mismatch");
    end else begin
      repeat (20) @(posedge clk);
      $display("sent %0d box pairs, checked %0d ratios (%0d zero union, %0d saturated)",
               n_sent, n_recv, n_zero_union, n_saturated);
      if (errors == 0 && expected_iou.size() == 0) $display("box3d_iou: match");
      else $display("box3d_iou: mismatch");
    end
    $finish;
  end
endmodule
